// ===== rtl/core/shrp_pkg.sv =====
// Shared types, register codes and reset values for the 3x3 sharpen stream filter.
// No dependencies; used by shrp_kernel and sharpen_3x3_stream_filter_unit.

package shrp_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int CFG_W   = 12;   // width and height register widths
    localparam int GAIN_W  = 16;   // signed 8.8 gain
    localparam int ROW_W   = 12;
    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 4;
    localparam int PIX_W   = CHAN_W * NUM_CH;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam logic [CFG_W-1:0]  WIDTH_RST  = 12'd1920;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 12'd1080;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd256;

    // Channel slots of a pixel word, red in the lowest byte.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef logic [NUM_CH-1:0][CHAN_W-1:0] pix_t;

    // The five pixels of the cross that the kernel looks at.
    typedef struct packed {
        pix_t north;
        pix_t west;
        pix_t center;
        pix_t east;
        pix_t south;
    } cross_t;

    typedef logic [2:0][CHAN_W-1:0] rgb_t;

endpackage

// ===== rtl/core/shrp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module shrp_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/shrp_kernel.sv =====
// Cross sharpen arithmetic for R, G and B: 5*center minus four neighbors, times gain,
// then clamp to 0..255. Depends on shrp_pkg.

module shrp_kernel (
    input  shrp_pkg::cross_t                   win,
    input  logic signed [shrp_pkg::GAIN_W-1:0] gain,
    output shrp_pkg::rgb_t                     rgb
);

    localparam int CONV_W = 12;
    localparam int PROD_W = CONV_W + shrp_pkg::GAIN_W;
    localparam int Q_W    = PROD_W - 8;

    for (genvar k = 0; k < 3; k++)
    begin : g_chan
        logic signed [CONV_W-1:0] conv;
        logic signed [PROD_W-1:0] prod;
        logic [Q_W-1:0]           quot;

        always_comb
        begin
            conv = CONV_W'({win.center[k], 2'b00}) + CONV_W'(win.center[k])
                 - CONV_W'(win.north[k]) - CONV_W'(win.south[k])
                 - CONV_W'(win.west[k]) - CONV_W'(win.east[k]);
            prod = PROD_W'(conv) * PROD_W'(gain);
            quot = prod[PROD_W-1:8];
            // Zero and negative products clamp to black.
            if (prod[PROD_W-1] || (prod == '0))
            begin
                rgb[k] = '0;
            end
            else if (|quot[Q_W-1:shrp_pkg::CHAN_W])
            begin
                rgb[k] = '1;
            end
            else
            begin
                rgb[k] = quot[shrp_pkg::CHAN_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/sharpen_3x3_stream_filter_unit.sv =====
// Top level of the 3x3 cross sharpen filter on an RGBA raster stream.
// Depends on shrp_pkg, shrp_ram (two line stores) and shrp_kernel.
//
//  channel   | role     | handshake              | payload
//  s_axis    | pixels   | s_axis_tvalid/tready   | tdata: R,G,B,A; tuser: frame_start
//  m_axis    | results  | m_axis_tvalid/tready   | tdata: col,row,R,G,B,A; tlast: last
//  cfg       | register | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One pixel beat is taken every clock while s_axis_tready is high. Each beat passes the
// line store read on the accept edge, then the window shift, then the kernel into a
// two-entry output buffer, from which its result is presented.
// The line stores are written on the first unstalled edge after they are read; a
// same-address hit is forwarded. s_axis_tready drops only while both output buffer
// entries are full. Reset clears control state only; the line stores need no clearing pass.

module sharpen_3x3_stream_filter_unit #(
    parameter int MAX_WIDTH = shrp_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH),
    parameter int OUT_W     = ((COL_W + shrp_pkg::ROW_W + shrp_pkg::PIX_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [shrp_pkg::PIX_W-1:0]    s_axis_tdata,   // red, green, blue, alpha
    input  logic                          s_axis_tuser,   // frame_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_W-1:0]              m_axis_tdata,   // out_col, out_row, red, green,
                                                          // blue, alpha, zero pad
    output logic                          m_axis_tlast,   // frame_last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [shrp_pkg::GAIN_W-1:0]   cfg_data
);

    localparam int ROW_W = shrp_pkg::ROW_W;
    localparam int EW    = (COL_W + 1 > shrp_pkg::CFG_W) ? COL_W + 1 : shrp_pkg::CFG_W;

    typedef struct packed {
        logic [shrp_pkg::CHAN_W-1:0] alpha;
        shrp_pkg::rgb_t              rgb;
        logic [ROW_W-1:0]            row;
        logic [COL_W-1:0]            col;
    } res_t;

    // Configuration registers
    logic [shrp_pkg::CFG_W-1:0]  width_reg;
    logic [shrp_pkg::CFG_W-1:0]  height_reg;
    logic [shrp_pkg::GAIN_W-1:0] gain_reg;

    // Position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Stage 1: line store read in flight
    logic                 s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]     s1_col_reg;
    shrp_pkg::pix_t       s1_px_reg;
    logic                 s1_emit_reg;
    logic                 s1_last_reg;
    logic [COL_W-1:0]     s1_ocol_reg;
    logic [ROW_W-1:0]     s1_orow_reg;
    logic                 s1_fwd_reg;
    shrp_pkg::pix_t       s1_fwd_above_reg;
    shrp_pkg::pix_t       s1_fwd_above2_reg;

    // Stage 2: window
    logic                 s2_valid_reg, s2_valid_next;
    logic                 s2_last_reg;
    logic [COL_W-1:0]     s2_ocol_reg;
    logic [ROW_W-1:0]     s2_orow_reg;
    shrp_pkg::pix_t       win_n2_reg, win_n1_reg;
    shrp_pkg::pix_t       win_e_reg, win_c_reg, win_w_reg;
    shrp_pkg::pix_t       win_s2_reg, win_s1_reg;

    // Output buffer
    res_t                 buf_reg [2];
    logic                 buf_last_reg [2];
    logic                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           cnt_reg, cnt_next;

    logic                 en, accept, s1_adv, push, pop;
    logic [EW-1:0]        eff_w, wid_ext;
    logic [ROW_W-1:0]     eff_h;
    logic [COL_W-1:0]     c_pre, c_cur;
    logic [ROW_W-1:0]     r_pre, r_cur;
    logic [ROW_W:0]       r_inc, r_nxt;
    logic [EW-1:0]        c_inc;
    logic                 wrap_in, emit_in, last_in, fwd_in;
    shrp_pkg::pix_t       px_in;
    logic [shrp_pkg::PIX_W-1:0] ram0_q, ram1_q;
    shrp_pkg::pix_t       above, above2;
    shrp_pkg::cross_t     nbr_win;
    shrp_pkg::rgb_t       rgb;
    res_t                 res_in, res_out;

    assign cfg_ready = 1'b1;

    assign en            = (cnt_reg != 2'd2);
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign s1_adv        = en && s1_valid_reg;
    assign push          = en && s2_valid_reg;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign px_in         = s_axis_tdata;

    // Effective frame size
    always_comb
    begin
        wid_ext = EW'(width_reg);
        if (wid_ext < EW'(3))
        begin
            eff_w = EW'(3);
        end
        else if (wid_ext > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = wid_ext;
        end
        eff_h = (height_reg < ROW_W'(3)) ? ROW_W'(3) : height_reg;
    end

    // Position of the incoming pixel and the counters after it. The entry check also
    // covers a size that shrank since the last pixel.
    always_comb
    begin
        c_pre   = s_axis_tuser ? '0 : col_reg;
        r_pre   = s_axis_tuser ? '0 : row_reg;
        wrap_in = (EW'(c_pre) >= eff_w);
        c_cur   = wrap_in ? '0 : c_pre;
        r_inc   = wrap_in ? ({1'b0, r_pre} + 1'b1) : {1'b0, r_pre};
        r_cur   = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[ROW_W-1:0];

        emit_in = (c_cur >= COL_W'(2)) && (r_cur >= ROW_W'(2));
        last_in = (EW'(c_cur) == eff_w - 1'b1) && (r_cur == eff_h - 1'b1);
        fwd_in  = s1_adv && (s1_col_reg == c_cur);

        c_inc   = EW'(c_cur) + 1'b1;
        r_nxt   = {1'b0, r_cur} + 1'b1;
        if (c_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (r_nxt >= {1'b0, eff_h}) ? '0 : r_nxt[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_cur;
        end
    end

    always_comb
    begin
        s1_valid_next = accept;
        s2_valid_next = s1_valid_reg && s1_emit_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // Line stores: ram0 holds the previous line, ram1 the line before it.
    shrp_ram #(
        .WIDTH (shrp_pkg::PIX_W),
        .DEPTH (MAX_WIDTH),
        .ADDR_W(COL_W)
    ) u_line0 (
        .clk    (clk),
        .wr_en  (s1_adv),
        .wr_addr(s1_col_reg),
        .wr_data(s1_px_reg),
        .rd_en  (accept),
        .rd_addr(c_cur),
        .rd_data(ram0_q)
    );

    shrp_ram #(
        .WIDTH (shrp_pkg::PIX_W),
        .DEPTH (MAX_WIDTH),
        .ADDR_W(COL_W)
    ) u_line1 (
        .clk    (clk),
        .wr_en  (s1_adv),
        .wr_addr(s1_col_reg),
        .wr_data(above),
        .rd_en  (accept),
        .rd_addr(c_cur),
        .rd_data(ram1_q)
    );

    assign above  = s1_fwd_reg ? s1_fwd_above_reg  : shrp_pkg::pix_t'(ram0_q);
    assign above2 = s1_fwd_reg ? s1_fwd_above2_reg : shrp_pkg::pix_t'(ram1_q);

    assign nbr_win.north  = win_n1_reg;
    assign nbr_win.west   = win_w_reg;
    assign nbr_win.center = win_c_reg;
    assign nbr_win.east   = win_e_reg;
    assign nbr_win.south  = win_s1_reg;

    shrp_kernel u_kernel (
        .win (nbr_win),
        .gain(gain_reg),
        .rgb (rgb)
    );

    assign res_in.alpha = win_c_reg[shrp_pkg::CH_ALPHA];
    assign res_in.rgb   = rgb;
    assign res_in.row   = s2_orow_reg;
    assign res_in.col   = s2_ocol_reg;

    assign res_out       = buf_reg[rd_ptr_reg];
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = OUT_W'(res_out);
    assign m_axis_tlast  = buf_last_reg[rd_ptr_reg];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= shrp_pkg::WIDTH_RST;
            height_reg   <= shrp_pkg::HEIGHT_RST;
            gain_reg     <= shrp_pkg::GAIN_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    shrp_pkg::REG_WIDTH:  width_reg  <= cfg_data[shrp_pkg::CFG_W-1:0];
                    shrp_pkg::REG_HEIGHT: height_reg <= cfg_data[shrp_pkg::CFG_W-1:0];
                    shrp_pkg::REG_GAIN:   gain_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (en)
            begin
                s1_valid_reg <= s1_valid_next;
                s2_valid_reg <= s2_valid_next;
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg        <= c_cur;
            s1_px_reg         <= px_in;
            s1_emit_reg       <= emit_in;
            s1_last_reg       <= last_in;
            s1_ocol_reg       <= c_cur - 1'b1;
            s1_orow_reg       <= r_cur - 1'b1;
            s1_fwd_reg        <= fwd_in;
            s1_fwd_above_reg  <= s1_px_reg;
            s1_fwd_above2_reg <= above;
        end
        if (s1_adv)
        begin
            win_n1_reg  <= win_n2_reg;
            win_n2_reg  <= above2;
            win_w_reg   <= win_c_reg;
            win_c_reg   <= win_e_reg;
            win_e_reg   <= above;
            win_s1_reg  <= win_s2_reg;
            win_s2_reg  <= s1_px_reg;
            s2_last_reg <= s1_last_reg;
            s2_ocol_reg <= s1_ocol_reg;
            s2_orow_reg <= s1_orow_reg;
        end
        if (push)
        begin
            buf_reg[wr_ptr_reg]      <= res_in;
            buf_last_reg[wr_ptr_reg] <= s2_last_reg;
        end
    end

    // The output buffer never holds more than two results.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    // Nothing is pushed into a full buffer.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push)
        else $error("push into full output buffer");

    // A read that hits the line store entry written in the same cycle is forwarded.
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_adv && (s1_col_reg == c_cur)) |=> s1_fwd_reg)
        else $error("line store hit not forwarded");

    // An emitted pixel is never on the left column or top row.
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((res_out.col != '0) && (res_out.row != '0)))
        else $error("border pixel emitted");

endmodule

// ===== tb/sharpen_3x3_stream_filter_unit_tb.sv =====
// Self-checking testbench for the 3x3 cross sharpen stream filter.
// Drives pixel, result and register channels and predicts every result beat in a scoreboard.
// Depends on shrp_pkg and sharpen_3x3_stream_filter_unit.

module sharpen_3x3_stream_filter_unit_tb;

    localparam int COL_W          = $clog2(shrp_pkg::MAX_WIDTH_DEF);
    localparam int OUT_W          = ((COL_W + shrp_pkg::ROW_W + shrp_pkg::PIX_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 600000;

    // Result beat as it sits in m_axis_tdata, column in the lowest bits.
    typedef struct packed {
        logic [OUT_W-COL_W-shrp_pkg::ROW_W-shrp_pkg::PIX_W-1:0] pad;
        logic [shrp_pkg::CHAN_W-1:0]                            alpha;
        logic [shrp_pkg::CHAN_W-1:0]                            blue;
        logic [shrp_pkg::CHAN_W-1:0]                            green;
        logic [shrp_pkg::CHAN_W-1:0]                            red;
        logic [shrp_pkg::ROW_W-1:0]                             row;
        logic [COL_W-1:0]                                       col;
    } out_beat_t;

    typedef struct packed {
        logic [COL_W-1:0]            col;
        logic [shrp_pkg::ROW_W-1:0]  row;
        logic [shrp_pkg::CHAN_W-1:0] red;
        logic [shrp_pkg::CHAN_W-1:0] green;
        logic [shrp_pkg::CHAN_W-1:0] blue;
        logic [shrp_pkg::CHAN_W-1:0] alpha;
        logic                        last;
    } px_result_t;

    typedef enum {FILL_SMOOTH, FILL_EXTREME, FILL_RANDOM} fill_t;

    class sharpen_scoreboard;
        logic [shrp_pkg::CFG_W-1:0]  width_reg;
        logic [shrp_pkg::CFG_W-1:0]  height_reg;
        logic [shrp_pkg::GAIN_W-1:0] gain_reg;
        shrp_pkg::pix_t              line_mem [2*shrp_pkg::MAX_WIDTH_DEF];
        shrp_pkg::pix_t              win [9];
        int unsigned                 col_pos;
        int unsigned                 row_pos;
        px_result_t                  expected_px [$];
        int                          errors;

        function new();
            width_reg  = shrp_pkg::WIDTH_RST;
            height_reg = shrp_pkg::HEIGHT_RST;
            gain_reg   = shrp_pkg::GAIN_RST;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i]) win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function int pending();
            return expected_px.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [shrp_pkg::GAIN_W-1:0] value);
            case (idx)
                shrp_pkg::REG_WIDTH:  width_reg  = value[shrp_pkg::CFG_W-1:0];
                shrp_pkg::REG_HEIGHT: height_reg = value[shrp_pkg::CFG_W-1:0];
                shrp_pkg::REG_GAIN:   gain_reg   = value;
                default: ;
            endcase
        endfunction

        // Cross kernel on one channel, then gain, clip at zero, floor and saturate.
        function logic [shrp_pkg::CHAN_W-1:0] sharpen(int k);
            int conv;
            int prod;
            conv = 5 * int'(win[4][k]) - int'(win[1][k]) - int'(win[7][k])
                 - int'(win[3][k]) - int'(win[5][k]);
            prod = conv * int'($signed(gain_reg));
            if (prod <= 0) return '0;
            if ((prod >> 8) > 255) return 8'd255;
            return shrp_pkg::CHAN_W'(prod >> 8);
        endfunction

        function void note_pixel(logic frame_start, shrp_pkg::pix_t px);
            int unsigned    w;
            int unsigned    h;
            int unsigned    c;
            int unsigned    r;
            shrp_pkg::pix_t above;
            shrp_pkg::pix_t above2;
            px_result_t     e;
            w = (width_reg < 3) ? 3 : ((width_reg > shrp_pkg::MAX_WIDTH_DEF) ?
                                       shrp_pkg::MAX_WIDTH_DEF : width_reg);
            h = (height_reg < 3) ? 3 : height_reg;
            if (frame_start)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            c = col_pos;
            r = row_pos;
            above  = line_mem[c];
            above2 = line_mem[shrp_pkg::MAX_WIDTH_DEF + c];
            for (int i = 0; i < 3; i++)
            begin
                win[3*i]   = win[3*i+1];
                win[3*i+1] = win[3*i+2];
            end
            win[2] = above2;
            win[5] = above;
            win[8] = px;
            line_mem[shrp_pkg::MAX_WIDTH_DEF + c] = above;
            line_mem[c] = px;
            // The window center is one line up and one column back.
            if (c >= 2 && r >= 2)
            begin
                e.col   = COL_W'(c - 1);
                e.row   = shrp_pkg::ROW_W'(r - 1);
                e.red   = sharpen(shrp_pkg::CH_RED);
                e.green = sharpen(shrp_pkg::CH_GREEN);
                e.blue  = sharpen(shrp_pkg::CH_BLUE);
                e.alpha = win[4][shrp_pkg::CH_ALPHA];
                e.last  = (c == w - 1) && (r == h - 1);
                expected_px = {expected_px, e};
            end
            col_pos = c + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        task compare(string name, int got, int want, px_result_t e);
            if (got != want)
                report($sformatf("%s at col %0d row %0d: got %0d, expected %0d",
                                 name, e.col, e.row, got, want));
        endtask

        task check_result(logic [OUT_W-1:0] data, logic last);
            out_beat_t  got;
            px_result_t e;
            got = data;
            if (expected_px.size() == 0)
            begin
                report($sformatf("result beat with nothing pending: col %0d row %0d",
                                 got.col, got.row));
                return;
            end
            e = expected_px.pop_front();
            compare("out_col", got.col, e.col, e);
            compare("out_row", got.row, e.row, e);
            compare("red_out", got.red, e.red, e);
            compare("green_out", got.green, e.green, e);
            compare("blue_out", got.blue, e.blue, e);
            compare("alpha_out", got.alpha, e.alpha, e);
            compare("frame_last", last, e.last, e);
        endtask
    endclass

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [shrp_pkg::PIX_W-1:0]  s_axis_tdata  = '0;
    logic                        s_axis_tuser  = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_W-1:0]            m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [1:0]                  cfg_index     = shrp_pkg::REG_WIDTH;
    logic [shrp_pkg::GAIN_W-1:0] cfg_data      = '0;

    sharpen_scoreboard sb;
    bit                steady = 1'b0;
    int                cycle_count = 0;

    sharpen_3x3_stream_filter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 13);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic shrp_pkg::pix_t make_pixel(fill_t mode, shrp_pkg::pix_t base);
        shrp_pkg::pix_t p;
        int             v;
        p = $urandom;
        for (int k = 0; k < shrp_pkg::NUM_CH; k++)
        begin
            v = int'(base[k]) + int'($urandom_range(8)) - 4;
            case (mode)
                FILL_SMOOTH:  p[k] = (v < 0) ? 8'd0 :
                                     ((v > 255) ? 8'd255 : shrp_pkg::CHAN_W'(v));
                FILL_EXTREME: p[k] = $urandom_range(1) ? 8'hFF : 8'h00;
                default: ;
            endcase
        end
        return p;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [shrp_pkg::GAIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic write_all(logic [shrp_pkg::GAIN_W-1:0] w, logic [shrp_pkg::GAIN_W-1:0] h,
                             logic [shrp_pkg::GAIN_W-1:0] g);
        write_reg(shrp_pkg::REG_WIDTH, w);
        write_reg(shrp_pkg::REG_HEIGHT, h);
        write_reg(shrp_pkg::REG_GAIN, g);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic frame_start, shrp_pkg::pix_t px);
        while (!steady && $urandom_range(99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= frame_start;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_pixel(frame_start, px);
    endtask

    task automatic send_frame(logic first_fs, int count, fill_t mode);
        shrp_pkg::pix_t base;
        base = $urandom;
        for (int i = 0; i < count; i++)
            send_pixel(first_fs && i == 0, make_pixel(mode, base));
    endtask

    // A 3x3 frame whose only interior pixel is the center.
    task automatic send_cross(logic first_fs, shrp_pkg::pix_t ctr, shrp_pkg::pix_t ring);
        for (int i = 0; i < 9; i++)
            send_pixel(first_fs && i == 0, (i == 4) ? ctr : ring);
    endtask

    // Let every pending result drain, then give beats that cause no result time to clear.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [shrp_pkg::GAIN_W-1:0] w_cfg;
        logic [shrp_pkg::GAIN_W-1:0] h_cfg;
        logic [shrp_pkg::GAIN_W-1:0] g_cfg;
        int                          w_eff;
        int                          h_eff;
        int                          frame_px;
        int                          nframes;
        int                          len;
        int                          pick;
        int                          random_items;
        logic                        fs;
        logic                        cut;
        fill_t                       mode;

        sb = new();
        random_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Width and height below the minimum both become 3, so each frame is 3x3.
        write_all(16'd2, 16'd0, 16'h7FFF);
        send_cross(1'b1, 32'h00FF_FFFF, 32'hFF00_0000);
        // No frame start here: the counters wrap on their own after the last pixel.
        send_cross(1'b0, 32'hFF00_0000, 32'h00FF_FFFF);
        // A short run cut off by a new frame start.
        send_frame(1'b1, 3, FILL_EXTREME);
        send_frame(1'b1, 9, FILL_EXTREME);
        finish_phase();

        // Stop at row 4 column 9, then shrink the frame: the column is past the new
        // width, so the next beat lands on column 0 of row 5.
        write_all(16'd12, 16'd9, 16'h0100);
        send_frame(1'b1, 57, FILL_SMOOTH);
        finish_phase();
        write_all(16'd7, 16'd6, 16'h8000);
        send_frame(1'b0, 7 + 2 * 42, FILL_SMOOTH);
        finish_phase();

        // A whole frame with no idling on either side.
        steady = 1'b1;
        write_all(16'd40, 16'd5, 16'h0180);
        send_frame(1'b1, 40 * 5, FILL_SMOOTH);
        finish_phase();
        steady = 1'b0;

        while (random_items < 600)
        begin
            pick = $urandom_range(99);
            if (pick < 70) w_eff = $urandom_range(16, 3);
            else if (pick < 80) w_eff = $urandom_range(2, 0);
            else if (pick < 90) w_eff = $urandom_range(64, 17);
            else w_eff = $urandom_range(4095, 2049);
            pick = $urandom_range(99);
            if (pick < 75) h_eff = $urandom_range(8, 3);
            else if (pick < 85) h_eff = $urandom_range(2, 0);
            else h_eff = $urandom_range(20, 9);
            w_cfg = {4'($urandom), 12'(w_eff)};
            h_cfg = {4'($urandom), 12'(h_eff)};
            pick = $urandom_range(99);
            if (pick < 50) g_cfg = shrp_pkg::GAIN_W'($urandom_range(16'h0400, 0));
            else if (pick < 70) g_cfg = -shrp_pkg::GAIN_W'($urandom_range(16'h0400, 1));
            else g_cfg = shrp_pkg::GAIN_W'($urandom);
            write_all(w_cfg, h_cfg, g_cfg);

            if (w_eff < 3) w_eff = 3;
            if (w_eff > shrp_pkg::MAX_WIDTH_DEF) w_eff = shrp_pkg::MAX_WIDTH_DEF;
            if (h_eff < 3) h_eff = 3;
            frame_px = w_eff * h_eff;
            if (frame_px > 300) frame_px = 300;
            nframes = $urandom_range(3, 1);
            cut = 1'b1;
            for (int f = 0; f < nframes; f++)
            begin
                fs  = cut || $urandom_range(1);
                len = frame_px;
                cut = ($urandom_range(9) == 0);
                if (cut) len = $urandom_range(frame_px, 1);
                pick = $urandom_range(99);
                if (pick < 60) mode = FILL_SMOOTH;
                else if (pick < 80) mode = FILL_EXTREME;
                else mode = FILL_RANDOM;
                send_frame(fs, len, mode);
                random_items += len;
            end
            finish_phase();
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
